/* rtl/olwd_pkg.sv */
// Shared types and constants for the ordered list with delete.
// Holds the list depth, derived widths, operation and status codes
// and the per-cell command word. Depends on nothing.
package olwd_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int DATA_W     = 32;

    typedef enum logic [1:0] {
        KIND_APPEND   = 2'd0,
        KIND_REM_HEAD = 2'd1,
        KIND_REM_KEY  = 2'd2,
        KIND_REM_TAIL = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Command word handed to every cell for one operation
    typedef struct packed {
        logic app_here;   // load the key into this cell
        logic rm_head;    // every cell takes its right neighbour's entry
        logic rm_key;     // cells at or after the first match take the neighbour's entry
    } t_cell_cmd;

endpackage

/* rtl/ordered_list_with_delete.sv */
// Ordered list with delete: a row of cells kept in insertion order.
// One operation per cycle; the result word appears in the cycle after the
// operation is taken, for one cycle, marked by o_valid. busy stays low.
// The first-match search ripples one flag through the row of cells.
// Synchronous active-low reset empties the list; entries are not cleared.
// Depends on olwd_pkg and olwd_cell.
module ordered_list_with_delete
    import olwd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_removed_value,
    output logic [CNT_W-1:0]         o_entry_count
);

    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    logic              r_valid;
    t_status           r_status;
    t_status           n_status;
    logic [DATA_W-1:0] r_removed;
    logic [DATA_W-1:0] n_removed;

    logic              go;
    t_kind             kind;
    logic              empty;
    logic              full;
    logic              found;
    logic [IDX_W-1:0]  tail_idx;

    logic [DATA_W-1:0] cell_data [LIST_DEPTH];
    logic [LIST_DEPTH:0] hit;
    t_cell_cmd         cmd       [LIST_DEPTH];

    assign busy     = 1'b0;
    assign go       = start & ~busy;
    assign kind     = t_kind'(i_kind);
    assign empty    = (r_fill == '0);
    assign full     = (r_fill == CNT_W'(LIST_DEPTH));
    assign tail_idx = IDX_W'(r_fill - CNT_W'(1));
    assign hit[0]   = 1'b0;
    assign found    = hit[LIST_DEPTH];

    // Build the row of cells, each told what to do for this word
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] next_data;

        if (g == LIST_DEPTH - 1) begin : g_last
            assign next_data = '0;
        end else begin : g_mid
            assign next_data = cell_data[g+1];
        end

        always_comb begin
            cmd[g].app_here = go && (kind == KIND_APPEND) && (r_fill == CNT_W'(g));
            cmd[g].rm_head  = go && (kind == KIND_REM_HEAD) && !empty;
            cmd[g].rm_key   = go && (kind == KIND_REM_KEY);
        end

        olwd_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (cmd[g]),
            .i_valid   (CNT_W'(g) < r_fill),
            .i_key     (i_value),
            .i_next    (next_data),
            .i_hit_in  (hit[g]),
            .o_hit_out (hit[g+1]),
            .o_data    (cell_data[g])
        );
    end

    // Work out status, removed word and new count
    always_comb begin
        n_fill    = r_fill;
        n_status  = ST_OK;
        n_removed = '0;
        case (kind)
            KIND_APPEND: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            KIND_REM_HEAD: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_removed = cell_data[0];
                    n_fill    = r_fill - CNT_W'(1);
                end
            end
            KIND_REM_TAIL: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_removed = cell_data[tail_idx];
                    n_fill    = r_fill - CNT_W'(1);
                end
            end
            default: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (!found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_removed = i_value;
                    n_fill    = r_fill - CNT_W'(1);
                end
            end
        endcase
    end

    // Hold the count and the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= go;
            if (go) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_entry_count   = r_fill;

endmodule

/* rtl/olwd_cell.sv */
// One slot of the list: holds an entry, compares it with the key and
// passes the first-match flag on to its right neighbour.
// Depends on olwd_pkg.
module olwd_cell
    import olwd_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_key,
    input  logic [DATA_W-1:0] i_next,
    input  logic              i_hit_in,
    output logic              o_hit_out,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // Flag a match here or in any earlier slot
    assign o_hit_out = i_hit_in | (i_valid & (r_data == i_key));

    // Load the key, advance the neighbour's entry, or hold
    always_comb begin
        if (i_cmd.app_here) begin
            n_data = i_key;
        end else if (i_cmd.rm_head || (i_cmd.rm_key && o_hit_out)) begin
            n_data = i_next;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
